// ===== hw/rtl/tbt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tbt_pkg;

    // Field widths
    localparam int RANGE_W   = 24;
    localparam int BEACON_W  = 24;
    localparam int POS_W     = 32;

    // Geometry terms
    localparam int DIFF_W    = BEACON_W + 1;        // beacon coordinate differences
    localparam int SQ_W      = 2 * RANGE_W;         // squares of ranges and coordinates
    localparam int K_W       = SQ_W + 1;            // sum of beacon squares per equation
    localparam int DPROD_W   = 2 * DIFF_W;          // difference products for det
    localparam int DET_W     = DPROD_W + 1;         // determinant, signed
    localparam int ABS_W     = DET_W - 1;           // |det|
    localparam int DIV_W     = DET_W;               // divisor 2*|det|

    // Numerator terms
    localparam int CF_W      = SQ_W + 3;            // right-hand sides C and F
    localparam int LO_W      = 26;                  // low slice of C/F for partial products
    localparam int HI_W      = CF_W - LO_W;         // high slice of C/F, signed
    localparam int PLO_W     = LO_W + 1 + DIFF_W;   // low partial product
    localparam int PHI_W     = HI_W + DIFF_W;       // high partial product
    localparam int PROD_W    = CF_W + DIFF_W;       // full product
    localparam int NUM_W     = PROD_W + 1;          // numerator, signed

    // Divider
    localparam int Q_W       = POS_W;               // quotient bits, one per stage
    localparam int TOP_W     = NUM_W - Q_W;         // dividend bits above the quotient window
    localparam int REM_W     = DIV_W + 1;           // partial remainder

    // Pipeline registers from input to last divider stage
    localparam int NST       = 42;

    // Saturation bounds
    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = BEACON_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_A_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_A_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_B_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_B_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_C_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_C_Y = 3'd5;

    // Input item
    typedef struct packed {
        logic [RANGE_W-1:0] range_a;
        logic [RANGE_W-1:0] range_b;
        logic [RANGE_W-1:0] range_c;
    } range_t;

    // Result item
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    singular;
        logic                    clipped;
    } pos_t;

    // Terms that depend on the beacons only
    typedef struct packed {
        logic signed [DIFF_W-1:0] dxab;
        logic signed [DIFF_W-1:0] dyab;
        logic signed [DIFF_W-1:0] dxbc;
        logic signed [DIFF_W-1:0] dybc;
        logic signed [K_W-1:0]    kab;
        logic signed [K_W-1:0]    kbc;
        logic [ABS_W-1:0]         abs_det;
        logic [DIV_W-1:0]         divisor;
        logic                     det_neg;
        logic                     det_zero;
    } geom_t;

    // Divider entry for one coordinate
    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   low;
    } div_in_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tbt_geom.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tbt_geom (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [tbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tbt_pkg::CFG_W-1:0]     cfg_data,
    output tbt_pkg::geom_t                     geom
);
    import tbt_pkg::*;

    logic signed [BEACON_W-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;

    logic signed [DIFF_W-1:0]   dxab_reg, dyab_reg, dxbc_reg, dybc_reg;
    logic signed [SQ_W-1:0]     ax2_reg, ay2_reg, bx2_reg, by2_reg, cx2_reg, cy2_reg;

    logic signed [K_W-1:0]      kab_reg, kbc_reg;
    logic signed [DPROD_W-1:0]  pd1_reg, pd2_reg;

    logic signed [DET_W-1:0]    det_reg;
    logic signed [DET_W-1:0]    det_negated;

    logic [ABS_W-1:0]           abs_det_reg;
    logic                       det_neg_reg;
    logic                       det_zero_reg;

    // Beacon registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg <= '0;
            ay_reg <= '0;
            bx_reg <= '0;
            by_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BEACON_A_X: ax_reg <= cfg_data;
                CFG_BEACON_A_Y: ay_reg <= cfg_data;
                CFG_BEACON_B_X: bx_reg <= cfg_data;
                CFG_BEACON_B_Y: by_reg <= cfg_data;
                CFG_BEACON_C_X: cx_reg <= cfg_data;
                CFG_BEACON_C_Y: cy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Level one: differences and squares
    always_ff @(posedge clk)
    begin
        dxab_reg <= DIFF_W'(bx_reg) - DIFF_W'(ax_reg);
        dyab_reg <= DIFF_W'(by_reg) - DIFF_W'(ay_reg);
        dxbc_reg <= DIFF_W'(cx_reg) - DIFF_W'(bx_reg);
        dybc_reg <= DIFF_W'(cy_reg) - DIFF_W'(by_reg);
        ax2_reg  <= ax_reg * ax_reg;
        ay2_reg  <= ay_reg * ay_reg;
        bx2_reg  <= bx_reg * bx_reg;
        by2_reg  <= by_reg * by_reg;
        cx2_reg  <= cx_reg * cx_reg;
        cy2_reg  <= cy_reg * cy_reg;
    end

    // Level two: beacon square sums and determinant products
    always_ff @(posedge clk)
    begin
        kab_reg <= K_W'(bx2_reg) + K_W'(by2_reg) - K_W'(ax2_reg) - K_W'(ay2_reg);
        kbc_reg <= K_W'(cx2_reg) + K_W'(cy2_reg) - K_W'(bx2_reg) - K_W'(by2_reg);
        pd1_reg <= dxab_reg * dybc_reg;
        pd2_reg <= dyab_reg * dxbc_reg;
    end

    // Level three: determinant
    always_ff @(posedge clk)
    begin
        det_reg <= DET_W'(pd1_reg) - DET_W'(pd2_reg);
    end

    assign det_negated = -det_reg;

    // Level four: magnitude, sign and zero test
    always_ff @(posedge clk)
    begin
        abs_det_reg  <= det_reg[DET_W-1] ? det_negated[ABS_W-1:0] : det_reg[ABS_W-1:0];
        det_neg_reg  <= det_reg[DET_W-1];
        det_zero_reg <= (det_reg == '0);
    end

    // Pack the terms for the datapath
    always_comb
    begin
        geom.dxab     = dxab_reg;
        geom.dyab     = dyab_reg;
        geom.dxbc     = dxbc_reg;
        geom.dybc     = dybc_reg;
        geom.kab      = kab_reg;
        geom.kbc      = kbc_reg;
        geom.abs_det  = abs_det_reg;
        geom.divisor  = {abs_det_reg, 1'b0};
        geom.det_neg  = det_neg_reg;
        geom.det_zero = det_zero_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tbt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tbt_front (
    input  wire logic            clk,
    input  wire logic            adv,
    input  wire tbt_pkg::range_t range_data,
    input  wire tbt_pkg::geom_t  geom,
    output tbt_pkg::div_in_t     div_x,
    output tbt_pkg::div_in_t     div_y
);
    import tbt_pkg::*;

    // Merge a split product back into one word
    function automatic logic signed [PROD_W-1:0] join_pp(
        input logic signed [PHI_W-1:0] hi,
        input logic signed [PLO_W-1:0] lo
    );
        return (PROD_W'(hi) <<< LO_W) + PROD_W'(lo);
    endfunction

    range_t                   range_reg;
    logic [SQ_W-1:0]          ra2_reg, rb2_reg, rc2_reg;
    logic signed [CF_W-1:0]   c_reg, f_reg;

    logic signed [LO_W:0]     c_lo, f_lo;
    logic signed [HI_W-1:0]   c_hi, f_hi;

    logic signed [PHI_W-1:0]  cdybc_hi_reg, fdyab_hi_reg, fdxab_hi_reg, cdxbc_hi_reg;
    logic signed [PLO_W-1:0]  cdybc_lo_reg, fdyab_lo_reg, fdxab_lo_reg, cdxbc_lo_reg;
    logic signed [PROD_W-1:0] cdybc_reg, fdyab_reg, fdxab_reg, cdxbc_reg;

    logic signed [NUM_W-1:0]  numx_reg, numy_reg;
    logic signed [NUM_W-1:0]  numx_negated, numy_negated;

    logic [NUM_W-1:0]         magx_reg, magy_reg;
    logic                     negx_reg, negy_reg;

    logic [NUM_W-1:0]         sumx_reg, sumy_reg;
    logic                     sumx_neg_reg, sumy_neg_reg;
    logic [TOP_W-1:0]         topx, topy;

    div_in_t                  div_x_reg, div_y_reg;

    assign c_lo = $signed({1'b0, c_reg[LO_W-1:0]});
    assign f_lo = $signed({1'b0, f_reg[LO_W-1:0]});
    assign c_hi = $signed(c_reg[CF_W-1:LO_W]);
    assign f_hi = $signed(f_reg[CF_W-1:LO_W]);

    assign numx_negated = -numx_reg;
    assign numy_negated = -numy_reg;

    assign topx = sumx_reg[NUM_W-1:Q_W];
    assign topy = sumy_reg[NUM_W-1:Q_W];

    // Advance all front stages together
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Capture the item
            range_reg <= range_data;

            // Square the ranges
            ra2_reg <= range_reg.range_a * range_reg.range_a;
            rb2_reg <= range_reg.range_b * range_reg.range_b;
            rc2_reg <= range_reg.range_c * range_reg.range_c;

            // Form the right-hand sides
            c_reg <= CF_W'(ra2_reg) - CF_W'(rb2_reg) + CF_W'(geom.kab);
            f_reg <= CF_W'(rb2_reg) - CF_W'(rc2_reg) + CF_W'(geom.kbc);

            // Split products into high and low halves
            cdybc_hi_reg <= c_hi * geom.dybc;
            cdybc_lo_reg <= c_lo * geom.dybc;
            fdyab_hi_reg <= f_hi * geom.dyab;
            fdyab_lo_reg <= f_lo * geom.dyab;
            fdxab_hi_reg <= f_hi * geom.dxab;
            fdxab_lo_reg <= f_lo * geom.dxab;
            cdxbc_hi_reg <= c_hi * geom.dxbc;
            cdxbc_lo_reg <= c_lo * geom.dxbc;

            // Recombine the halves
            cdybc_reg <= join_pp(cdybc_hi_reg, cdybc_lo_reg);
            fdyab_reg <= join_pp(fdyab_hi_reg, fdyab_lo_reg);
            fdxab_reg <= join_pp(fdxab_hi_reg, fdxab_lo_reg);
            cdxbc_reg <= join_pp(cdxbc_hi_reg, cdxbc_lo_reg);

            // Cramer numerators
            numx_reg <= NUM_W'(cdybc_reg) - NUM_W'(fdyab_reg);
            numy_reg <= NUM_W'(fdxab_reg) - NUM_W'(cdxbc_reg);

            // Take magnitude and quotient sign
            magx_reg <= numx_reg[NUM_W-1] ? numx_negated : numx_reg;
            magy_reg <= numy_reg[NUM_W-1] ? numy_negated : numy_reg;
            negx_reg <= numx_reg[NUM_W-1] ^ geom.det_neg;
            negy_reg <= numy_reg[NUM_W-1] ^ geom.det_neg;

            // Add half the divisor for round half away from zero
            sumx_reg     <= magx_reg + NUM_W'(geom.abs_det);
            sumy_reg     <= magy_reg + NUM_W'(geom.abs_det);
            sumx_neg_reg <= negx_reg;
            sumy_neg_reg <= negy_reg;

            // Detect quotient overflow and seed the divider
            div_x_reg.neg <= sumx_neg_reg;
            div_x_reg.ovf <= REM_W'(topx) >= REM_W'(geom.divisor);
            div_x_reg.rem <= REM_W'(topx);
            div_x_reg.low <= sumx_reg[Q_W-1:0];
            div_y_reg.neg <= sumy_neg_reg;
            div_y_reg.ovf <= REM_W'(topy) >= REM_W'(geom.divisor);
            div_y_reg.rem <= REM_W'(topy);
            div_y_reg.low <= sumy_reg[Q_W-1:0];
        end
    end

    assign div_x = div_x_reg;
    assign div_y = div_y_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tbt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tbt_div (
    input  wire logic                      clk,
    input  wire logic                      adv,
    input  wire tbt_pkg::div_in_t          div_in,
    input  wire logic [tbt_pkg::DIV_W-1:0] divisor,
    output logic [tbt_pkg::POS_W-1:0]      pos,
    output logic                           clip
);
    import tbt_pkg::*;

    logic [REM_W-1:0] rem_reg  [0:Q_W-1];
    logic [Q_W-1:0]   quo_reg  [0:Q_W-1];
    logic [Q_W-1:0]   low_reg  [0:Q_W-1];
    logic             neg_reg  [0:Q_W-1];
    logic             ovf_reg  [0:Q_W-1];

    logic [REM_W-1:0] rem_src  [0:Q_W-1];
    logic [Q_W-1:0]   quo_src  [0:Q_W-1];
    logic [Q_W-1:0]   low_src  [0:Q_W-1];
    logic             neg_src  [0:Q_W-1];
    logic             ovf_src  [0:Q_W-1];

    logic [REM_W-1:0] shifted  [0:Q_W-1];
    logic [REM_W:0]   trial    [0:Q_W-1];
    logic             fit      [0:Q_W-1];

    logic [REM_W-1:0] rem_next [0:Q_W-1];
    logic [Q_W-1:0]   quo_next [0:Q_W-1];
    logic [Q_W-1:0]   low_next [0:Q_W-1];

    logic [Q_W-1:0]   q_fin;
    logic [Q_W-1:0]   q_negated;
    logic [Q_W-1:0]   limit;
    logic             over;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos_reg;
    logic             clip_reg;

    // Feed each step from the one before it
    always_comb
    begin
        rem_src[0] = div_in.rem;
        quo_src[0] = '0;
        low_src[0] = div_in.low;
        neg_src[0] = div_in.neg;
        ovf_src[0] = div_in.ovf;
        for (int j = 1; j < Q_W; j++)
        begin
            rem_src[j] = rem_reg[j-1];
            quo_src[j] = quo_reg[j-1];
            low_src[j] = low_reg[j-1];
            neg_src[j] = neg_reg[j-1];
            ovf_src[j] = ovf_reg[j-1];
        end
    end

    // One restoring step per stage, most significant quotient bit first
    always_comb
    begin
        for (int j = 0; j < Q_W; j++)
        begin
            shifted[j]  = {rem_src[j][REM_W-2:0], low_src[j][Q_W-1]};
            trial[j]    = {1'b0, shifted[j]} - {2'b00, divisor};
            fit[j]      = !trial[j][REM_W];
            rem_next[j] = fit[j] ? trial[j][REM_W-1:0] : shifted[j];
            quo_next[j] = {quo_src[j][Q_W-2:0], fit[j]};
            low_next[j] = {low_src[j][Q_W-2:0], 1'b0};
        end
    end

    // Saturate and apply the sign
    assign q_fin     = quo_reg[Q_W-1];
    assign q_negated = -q_fin;
    assign limit     = neg_reg[Q_W-1] ? POS_MIN : POS_MAX;
    assign over      = ovf_reg[Q_W-1] || (q_fin > limit);

    always_comb
    begin
        if (over)
        begin
            pos_next = limit;
        end
        else if (neg_reg[Q_W-1])
        begin
            pos_next = q_negated;
        end
        else
        begin
            pos_next = q_fin;
        end
    end

    // Advance the divider stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < Q_W; j++)
            begin
                rem_reg[j] <= rem_next[j];
                quo_reg[j] <= quo_next[j];
                low_reg[j] <= low_next[j];
                neg_reg[j] <= neg_src[j];
                ovf_reg[j] <= ovf_src[j];
            end
            pos_reg  <= pos_next;
            clip_reg <= over;
        end
    end

    assign pos  = pos_reg;
    assign clip = clip_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/three_beacon_trilateration.sv =====
// Three-beacon 2D trilateration, fixed point with 8 fractional bits.
//
// Configuration: write beacon coordinates through cfg_write / cfg_index /
// cfg_data while no item is in flight; indices 0..5 are a.x, a.y, b.x, b.y,
// c.x, c.y, and other indices are ignored. All beacons are zero after reset.
// Input channel range_*: one item carries the three ranges and is accepted
// when range_valid is high and range_stall is low.
// Result channel pos_*: one item per input item, in order, with position,
// singular flag (collinear beacons, position zero) and clipped flag.
// Each item passes through 9 front stages (squares, split products,
// rounding offset) and a 32-stage restoring divider with one final
// saturation stage before its result appears on pos_data.
// Throughput: one item per cycle sustained while the skid register is empty.
// When the receiver stalls, the output register holds its item and a skid
// register takes one more; the pipeline and range_stall hold only while the
// skid register is full. Reset empties the pipeline and both output registers.
`timescale 1ns / 1ps
`default_nettype none

module three_beacon_trilateration (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [tbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tbt_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          range_valid,
    output logic                               range_stall,
    input  wire tbt_pkg::range_t               range_data,
    output logic                               pos_valid,
    input  wire logic                          pos_stall,
    output tbt_pkg::pos_t                      pos_data
);
    import tbt_pkg::*;

    geom_t            geom;
    div_in_t          div_x, div_y;
    logic [POS_W-1:0] pos_x_q, pos_y_q;
    logic             clip_x, clip_y;

    logic             adv;
    logic             take;
    logic [NST-1:0]   valid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    pos_t             res;
    pos_t             out_reg;
    pos_t             skid_reg;

    tbt_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    tbt_front u_front (
        .clk        (clk),
        .adv        (adv),
        .range_data (range_data),
        .geom       (geom),
        .div_x      (div_x),
        .div_y      (div_y)
    );

    tbt_div u_div_x (
        .clk     (clk),
        .adv     (adv),
        .div_in  (div_x),
        .divisor (geom.divisor),
        .pos     (pos_x_q),
        .clip    (clip_x)
    );

    tbt_div u_div_y (
        .clk     (clk),
        .adv     (adv),
        .div_in  (div_y),
        .divisor (geom.divisor),
        .pos     (pos_y_q),
        .clip    (clip_y)
    );

    // Hold the pipeline only while the skid register is occupied
    assign adv         = !skid_valid_reg;
    assign range_stall = skid_valid_reg;
    assign take        = out_valid_reg && !pos_stall;

    // Zero the result for a singular system
    always_comb
    begin
        res.pos_x    = geom.det_zero ? '0 : pos_x_q;
        res.pos_y    = geom.det_zero ? '0 : pos_y_q;
        res.singular = geom.det_zero;
        res.clipped  = !geom.det_zero && (clip_x || clip_y);
    end

    // Advance item valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NST-2:0], range_valid};
        end
    end

    // Output and skid occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (valid_reg[NST-1])
            begin
                if (!out_valid_reg || take)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (take)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    // Output and skid payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (valid_reg[NST-1])
            begin
                if (!out_valid_reg || take)
                begin
                    out_reg <= res;
                end
                else
                begin
                    skid_reg <= res;
                end
            end
        end
        else if (take)
        begin
            out_reg <= skid_reg;
        end
    end

    assign pos_valid = out_valid_reg;
    assign pos_data  = out_reg;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tbt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 60;
    localparam int MAX_PRINTS     = 40;
    localparam int EXPECT_DEPTH   = 256;
    localparam int EXPECT_IDX_W   = 8;

    // Indexes past the last beacon register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;

    localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

    typedef enum int {GEO_FIELD, GEO_FULL, GEO_TINY, GEO_LINE} geo_kind_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 range_valid;
    logic                 range_stall;
    range_t               range_data;
    logic                 pos_valid;
    logic                 pos_stall;
    pos_t                 pos_data;

    // Beacon registers as the block should hold them
    logic signed [BEACON_W-1:0] beacon_regs [0:5];
    // Beacon layout in use, as plain integers for range generation
    int geo_x [0:2];
    int geo_y [0:2];

    // Predicted results in order of acceptance, as a ring with running counts
    pos_t expected_ring [0:EXPECT_DEPTH-1];
    int   expected_wr;
    int   expected_rd;
    pos_t want_pos;
    int   mismatches;
    int   prints;
    int   results_seen;
    int   idle_pct;
    int   stall_pct;
    int   hold_requests;
    int   holds_served;
    int   hold_left;
    int   quiet_cycles;

    three_beacon_trilateration uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .range_valid (range_valid),
        .range_stall (range_stall),
        .range_data  (range_data),
        .pos_valid   (pos_valid),
        .pos_stall   (pos_stall),
        .pos_data    (pos_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Divide and round half away from zero, clamp to 32 bits
    function automatic logic [POS_W-1:0] round_div(input logic signed [127:0] num,
                                                   input logic signed [127:0] det,
                                                   output logic clip);
        logic [127:0] mag_num;
        logic [127:0] mag_det;
        logic [127:0] quo;
        logic [127:0] bound;
        logic         neg;
        neg     = (num < 0) != (det < 0);
        mag_num = (num < 0) ? -num : num;
        mag_det = (det < 0) ? -det : det;
        quo     = (mag_num + mag_det) / (mag_det * 2);
        bound   = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        clip    = quo > bound;
        if (clip)
            quo = bound;
        if (neg)
            quo = -quo;
        return quo[POS_W-1:0];
    endfunction

    // Solve the two difference equations by Cramer's rule
    function automatic pos_t predict_position(input range_t r);
        logic signed [127:0] ax, ay, bx, by, cx, cy, ra, rb, rc;
        logic signed [127:0] dxab, dyab, dxbc, dybc, c_rhs, f_rhs, det;
        logic                clip_x, clip_y;
        pos_t                p;
        ax = beacon_regs[CFG_BEACON_A_X];
        ay = beacon_regs[CFG_BEACON_A_Y];
        bx = beacon_regs[CFG_BEACON_B_X];
        by = beacon_regs[CFG_BEACON_B_Y];
        cx = beacon_regs[CFG_BEACON_C_X];
        cy = beacon_regs[CFG_BEACON_C_Y];
        ra = r.range_a;
        rb = r.range_b;
        rc = r.range_c;
        dxab  = bx - ax;
        dyab  = by - ay;
        dxbc  = cx - bx;
        dybc  = cy - by;
        c_rhs = ra * ra - rb * rb - ax * ax + bx * bx - ay * ay + by * by;
        f_rhs = rb * rb - rc * rc - bx * bx + cx * cx - by * by + cy * cy;
        det   = dxab * dybc - dyab * dxbc;
        p = '0;
        if (det == 0)
        begin
            p.singular = 1'b1;
            return p;
        end
        p.pos_x   = round_div(c_rhs * dybc - f_rhs * dyab, det, clip_x);
        p.pos_y   = round_div(f_rhs * dxab - c_rhs * dxbc, det, clip_y);
        p.clipped = clip_x | clip_y;
        return p;
    endfunction

    // Distance in LSB units, with a small error added
    function automatic logic [RANGE_W-1:0] range_from(input int x0, input int y0,
                                                      input int x1, input int y1);
        real dx;
        real dy;
        int  d;
        dx = x1 - x0;
        dy = y1 - y0;
        d  = $rtoi($sqrt(dx * dx + dy * dy) + 0.5) + int'($urandom_range(8)) - 4;
        if (d < 0)
            d = 0;
        return d[RANGE_W-1:0];
    endfunction

    function automatic logic [RANGE_W-1:0] random_range();
        if ($urandom_range(1))
            return RANGE_W'($urandom_range(4095));
        return RANGE_W'($urandom_range(RANGE_MAX));
    endfunction

    // Mostly ranges from a true point near the beacons, the rest noise; GEO_FULL gets noise only
    function automatic range_t random_ranges(input geo_kind_t kind);
        range_t r;
        int     px;
        int     py;
        px = int'($urandom_range(65535)) - 32768;
        py = int'($urandom_range(65535)) - 32768;
        if (kind != GEO_FULL && $urandom_range(99) < 80)
        begin
            r.range_a = range_from(geo_x[0], geo_y[0], px, py);
            r.range_b = range_from(geo_x[1], geo_y[1], px, py);
            r.range_c = range_from(geo_x[2], geo_y[2], px, py);
        end
        else
        begin
            r.range_a = random_range();
            r.range_b = random_range();
            r.range_c = random_range();
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (prints < MAX_PRINTS)
            $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
        prints++;
    endtask

    task automatic compare_field(input string name, input logic [POS_W-1:0] got,
                                 input logic [POS_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Check each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && pos_valid === 1'b1 && pos_stall === 1'b0)
        begin
            if (expected_rd == expected_wr)
                report_mismatch("result with nothing expected");
            else
            begin
                want_pos = expected_ring[expected_rd[EXPECT_IDX_W-1:0]];
                expected_rd++;
                compare_field("pos_x", pos_data.pos_x, want_pos.pos_x);
                compare_field("pos_y", pos_data.pos_y, want_pos.pos_y);
                compare_field("singular", POS_W'(pos_data.singular),
                              POS_W'(want_pos.singular));
                compare_field("clipped", POS_W'(pos_data.clipped),
                              POS_W'(want_pos.clipped));
            end
            results_seen++;
        end
    end

    // Drive result stall: random, or a long hold on request
    always @(posedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            pos_stall    <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            pos_stall <= 1'b1;
        end
        else
            pos_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((range_valid === 1'b1 && range_stall === 1'b0)
            || (pos_valid === 1'b1 && pos_stall === 1'b0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no progress, %0d results outstanding",
                     $realtime, expected_wr - expected_rd);
            $display("three_beacon_trilateration verification failed");
            $finish;
        end
    end

    // Offer one item, hold it until taken, then record its prediction
    task automatic offer_ranges(input range_t item);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            range_valid <= 1'b0;
            @(posedge clk);
        end
        range_valid <= 1'b1;
        range_data  <= item;
        do
            @(posedge clk);
        while (range_stall);
        expected_ring[expected_wr[EXPECT_IDX_W-1:0]] = predict_position(item);
        expected_wr++;
    endtask

    task automatic wait_positions_drained();
        range_valid <= 1'b0;
        while (expected_wr != expected_rd)
            @(posedge clk);
    endtask

    // Write one register; the caller lowers the write enable when done
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(posedge clk);
        if (idx <= CFG_BEACON_C_Y)
            beacon_regs[idx] = value[BEACON_W-1:0];
    endtask

    task automatic set_beacons(input int ax, input int ay, input int bx, input int by,
                               input int cx, input int cy);
        wait_positions_drained();
        write_reg(CFG_BEACON_A_X, ax);
        write_reg(CFG_BEACON_A_Y, ay);
        write_reg(CFG_BEACON_B_X, bx);
        write_reg(CFG_BEACON_B_Y, by);
        write_reg(CFG_BEACON_C_X, cx);
        write_reg(CFG_BEACON_C_Y, cy);
        cfg_write <= 1'b0;
        geo_x[0] = ax; geo_y[0] = ay;
        geo_x[1] = bx; geo_y[1] = by;
        geo_x[2] = cx; geo_y[2] = cy;
    endtask

    // Pick a beacon layout of the given kind
    task automatic load_random_beacons(input geo_kind_t kind);
        int v [0:5];
        int sx;
        int sy;
        int k;
        foreach (v[i])
        begin
            case (kind)
                GEO_FULL: v[i] = int'($urandom) >>> 8;
                GEO_TINY: v[i] = int'($urandom_range(8)) - 4;
                default:  v[i] = int'($urandom_range(65535)) - 32768;
            endcase
        end
        if (kind == GEO_LINE)
        begin
            // Put all three on one line, possibly on top of each other
            sx   = int'($urandom_range(2047)) - 1024;
            sy   = int'($urandom_range(2047)) - 1024;
            k    = int'($urandom_range(6)) - 3;
            v[2] = v[0] + sx;
            v[3] = v[1] + sy;
            v[4] = v[0] + k * sx;
            v[5] = v[1] + k * sy;
        end
        set_beacons(v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    task automatic test_reset_state();
        // All beacons still zero: every item is singular
        offer_ranges('{range_a: '0, range_b: '0, range_c: '0});
        offer_ranges('{range_a: RANGE_MAX, range_b: RANGE_MAX, range_c: RANGE_MAX});
    endtask

    task automatic test_directed();
        // Right triangle, 10 units on a side
        set_beacons(0, 0, 2560, 0, 0, 2560);
        offer_ranges('{range_a: range_from(0, 0, 768, 1024),
                       range_b: range_from(2560, 0, 768, 1024),
                       range_c: range_from(0, 2560, 768, 1024)});
        offer_ranges('{range_a: '0, range_b: '0, range_c: '0});
        offer_ranges('{range_a: RANGE_MAX, range_b: RANGE_MAX, range_c: RANGE_MAX});
        offer_ranges('{range_a: RANGE_MAX, range_b: '0, range_c: '0});
        offer_ranges('{range_a: '0, range_b: RANGE_MAX, range_c: '0});
        offer_ranges('{range_a: '0, range_b: '0, range_c: RANGE_MAX});
        offer_ranges('{range_a: 24'hAAAAAA, range_b: 24'h555555, range_c: 24'hAAAAAA});

        // Writes past the last register must leave the beacons alone
        wait_positions_drained();
        write_reg(CFG_UNUSED_6, 24'h7FFFFF);
        write_reg(CFG_UNUSED_7, 24'h800000);
        cfg_write <= 1'b0;
        offer_ranges('{range_a: 24'h000500, range_b: 24'h000810, range_c: 24'h0006B5});
        offer_ranges('{range_a: 24'h123456, range_b: 24'h0, range_c: 24'h654321});

        // Unit triangle: exact halves round away from zero, large ranges clip
        set_beacons(0, 0, 1, 0, 0, 1);
        offer_ranges('{range_a: '0, range_b: '0, range_c: '0});
        offer_ranges('{range_a: '0, range_b: 24'd2, range_c: '0});
        offer_ranges('{range_a: RANGE_MAX, range_b: '0, range_c: '0});
        offer_ranges('{range_a: '0, range_b: RANGE_MAX, range_c: '0});
        offer_ranges('{range_a: '0, range_b: '0, range_c: RANGE_MAX});

        // Beacons at the corners of the coordinate range
        set_beacons(-8388608, -8388608, 8388607, -8388608, -8388608, 8388607);
        offer_ranges('{range_a: '0, range_b: '0, range_c: '0});
        offer_ranges('{range_a: RANGE_MAX, range_b: RANGE_MAX, range_c: RANGE_MAX});
        offer_ranges('{range_a: RANGE_MAX, range_b: '0, range_c: 24'h800000});

        // Collinear, then coincident beacons
        set_beacons(0, 0, 256, 256, 512, 512);
        offer_ranges('{range_a: 24'h000100, range_b: 24'h000200, range_c: 24'h000300});
        offer_ranges('{range_a: RANGE_MAX, range_b: '0, range_c: RANGE_MAX});
        set_beacons(1000, -1000, 1000, -1000, 1000, -1000);
        offer_ranges('{range_a: 24'h001000, range_b: 24'h002000, range_c: 24'h003000});
    endtask

    task automatic test_random_geometry(input int layouts, input int items_each);
        geo_kind_t kind;
        for (int n = 0; n < layouts; n++)
        begin
            case (n % 5)
                0, 1:    kind = GEO_FIELD;
                2:       kind = GEO_FULL;
                3:       kind = GEO_TINY;
                default: kind = GEO_LINE;
            endcase
            load_random_beacons(kind);
            repeat (items_each) offer_ranges(random_ranges(kind));
        end
    endtask

    task automatic test_no_idle_stretch();
        load_random_beacons(GEO_FIELD);
        idle_pct  = 0;
        stall_pct <= 0;
        repeat (100) offer_ranges(random_ranges(GEO_FIELD));
        idle_pct  = 24;
        stall_pct <= 24;
    endtask

    task automatic test_backpressure();
        // Hold the result side while items keep coming, until the input stalls
        load_random_beacons(GEO_FIELD);
        idle_pct = 0;
        hold_requests <= hold_requests + 1;
        repeat (120) offer_ranges(random_ranges(GEO_FIELD));
        idle_pct = 24;
        // Pause the sender until every result is back, then resume
        wait_positions_drained();
        repeat (30) offer_ranges(random_ranges(GEO_FIELD));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        range_valid   = 1'b0;
        range_data    = '0;
        pos_stall     = 1'b0;
        expected_wr   = 0;
        expected_rd   = 0;
        mismatches    = 0;
        prints        = 0;
        results_seen  = 0;
        idle_pct      = 24;
        stall_pct     = 24;
        hold_requests = 0;
        holds_served  = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        foreach (beacon_regs[i])
            beacon_regs[i] = '0;
        foreach (geo_x[i])
        begin
            geo_x[i] = 0;
            geo_y[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed();
        test_random_geometry(10, 90);
        test_no_idle_stretch();
        test_backpressure();

        // Let the pipeline empty, then watch for stray results
        wait_positions_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_wr != expected_rd)
            report_mismatch("predictions left without a result");
        if (mismatches == 0)
            $display("three_beacon_trilateration verification clean");
        else
            $display("three_beacon_trilateration verification failed");
        $finish;
    end

endmodule

// ===== three_beacon_trilateration.f =====
hw/rtl/tbt_pkg.sv
hw/rtl/tbt_geom.sv
hw/rtl/tbt_front.sv
hw/rtl/tbt_div.sv
hw/rtl/three_beacon_trilateration.sv
tb/tb_top.sv
